FILE: hw/rtl/tsts_pkg.sv
// tsts_pkg: shared widths, codes and the cell command struct of the
// tick/sleep time-slice scheduler; depends on nothing
package tsts_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int OPCODE_W  = 3;
    localparam int UNITS_W   = 16;
    localparam int DPID_W    = 4;
    localparam int KIND_W    = 2;
    localparam int PID_W     = 4;
    localparam int TICK_W    = 32;
    localparam int RUN_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] SLICE_RST = 16'd10;
    localparam logic [CFG_W-1:0] TPU_RST   = 16'd100;

    // input opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CREATE   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SLEEP    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DISPATCH = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_GETPID   = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PUSH     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CR_FAIL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PID      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RUN_CLR  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPU   = 1'd1;

    // slot state codes
    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_READY    = 2'd1;
    localparam logic [1:0] SLOT_RUNNING  = 2'd2;
    localparam logic [1:0] SLOT_SLEEPING = 2'd3;

    // cell operations
    localparam logic [2:0] CELL_NOP      = 3'd0;
    localparam logic [2:0] CELL_CMP      = 3'd1;
    localparam logic [2:0] CELL_SHIFT    = 3'd2;
    localparam logic [2:0] CELL_CREATE   = 3'd3;
    localparam logic [2:0] CELL_SLEEP    = 3'd4;
    localparam logic [2:0] CELL_DISPATCH = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic              run_en;
        logic [CFG_W-1:0]  slice_lim;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] wake;
    } t_cell_cmd;

endpackage

FILE: hw/rtl/tsts_cell.sv
// tsts_cell: one process slot (state, wake time, run time) and one stage
// of the wake-flag shift chain; depends on tsts_pkg
module tsts_cell
    import tsts_pkg::*;
#(
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_cmd     i_cmd,
    input  logic [IW-1:0] i_sel,
    input  logic          i_flag,
    output logic          o_flag,
    output logic          o_preempt
);

    logic [1:0]        r_state;
    logic [TICK_W-1:0] r_wake;
    logic [RUN_W-1:0]  r_run;
    logic              r_flag;

    logic              w_hit;
    logic              w_match;
    logic              w_run_hit;
    logic [RUN_W-1:0]  w_run_inc;

    assign w_hit     = (i_sel == IW'(IDX));
    assign w_match   = (r_state == SLOT_SLEEPING) && (r_wake == i_cmd.tick);
    assign w_run_hit = (i_cmd.op == CELL_CMP) && i_cmd.run_en && w_hit;
    // run time saturates
    assign w_run_inc = (r_run == {RUN_W{1'b1}}) ? r_run : r_run + 1'b1;
    assign o_preempt = w_run_hit && (w_run_inc >= i_cmd.slice_lim);
    assign o_flag    = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SLOT_FREE;
            r_wake  <= '0;
            r_run   <= '0;
            r_flag  <= 1'b0;
        end else begin
            case (i_cmd.op)
                CELL_CMP: begin
                    r_flag <= w_match;
                    if (w_match || o_preempt) begin
                        r_state <= SLOT_READY;
                    end
                    if (w_run_hit) begin
                        r_run <= w_run_inc;
                    end
                end
                CELL_SHIFT: begin
                    r_flag <= i_flag;
                end
                CELL_CREATE: begin
                    if (w_hit) begin
                        r_state <= SLOT_READY;
                        r_wake  <= '0;
                        r_run   <= '0;
                    end
                end
                CELL_SLEEP: begin
                    if (w_hit) begin
                        r_state <= SLOT_SLEEPING;
                        r_wake  <= i_cmd.wake;
                    end
                end
                CELL_DISPATCH: begin
                    if (w_hit) begin
                        r_state <= SLOT_RUNNING;
                        r_run   <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/tick_sleep_timeslice_scheduler.sv
// tick_sleep_timeslice_scheduler: create and get-pid answer in the cycle after
// accept, sleep answers via S_SLP if a process runs, dispatch gives no result; a
// tick holds busy through S_CMP, S_SCAN and S_FIN, taking no new item till then;
// the wake-flag chain shifts one slot per cycle in S_SCAN; a tick's results strobe
// out in slot order during the scan, a preemption last; results are strobes, the
// receiver cannot stall; synchronous reset frees all slots, clears the tick count
module tick_sleep_timeslice_scheduler
    import tsts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [UNITS_W-1:0]   i_sleep_units,
    input  logic [DPID_W-1:0]    i_dispatch_pid,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [KIND_W-1:0]    o_kind,
    output logic [PID_W-1:0]     o_pid,
    output logic                 o_none_running,
    output logic                 o_last
);

    localparam int IW = $clog2(SLOT_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_SLP  = 3'd4;

    logic [2:0]        r_state,     n_state;
    logic [IW-1:0]     r_cnt,       n_cnt;
    logic [TICK_W-1:0] r_tick,      n_tick;
    logic [CFG_W-1:0]  r_ts,        n_ts;
    logic [CFG_W-1:0]  r_tpu,       n_tpu;
    logic [IW-1:0]     r_run_slot,  n_run_slot;
    logic              r_run_valid, n_run_valid;
    logic [IW:0]       r_nfs,       n_nfs;
    logic [TICK_W-1:0] r_prod,      n_prod;
    logic              r_preempt,   n_preempt;
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind,      n_kind;
    logic [PID_W-1:0]  r_pid,       n_pid;
    logic              r_none,      n_none;
    logic              r_last,      n_last;

    t_cell_cmd             w_cmd;
    logic [IW-1:0]         w_sel;
    logic [SLOT_COUNT-1:0] w_flag;
    logic [SLOT_COUNT-1:0] w_flag_in;
    logic [SLOT_COUNT-1:0] w_preempt;
    logic                  w_full;
    logic                  w_dpid_ok;

    assign w_full    = (r_nfs >= (IW+1)'(SLOT_COUNT));
    assign w_dpid_ok = (32'(i_dispatch_pid) < SLOT_COUNT);
    assign busy      = (r_state != S_IDLE);

    // command broadcast to the slot cells
    always_comb begin
        w_cmd.op        = CELL_NOP;
        w_cmd.run_en    = r_run_valid && (r_run_slot != '0);
        w_cmd.slice_lim = r_ts;
        w_cmd.tick      = r_tick;
        w_cmd.wake      = r_tick + r_prod;
        w_sel           = r_run_slot;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_opcode)
                        OP_CREATE: begin
                            if (!w_full) begin
                                w_cmd.op = CELL_CREATE;
                                w_sel    = r_nfs[IW-1:0];
                            end
                        end
                        OP_DISPATCH: begin
                            if (w_dpid_ok) begin
                                w_cmd.op = CELL_DISPATCH;
                                w_sel    = IW'(i_dispatch_pid);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CMP:   w_cmd.op = CELL_CMP;
            S_SCAN:  w_cmd.op = CELL_SHIFT;
            S_SLP:   w_cmd.op = CELL_SLEEP;
            default: w_cmd.op = CELL_NOP;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
            if (gi == SLOT_COUNT - 1) begin : g_end
                assign w_flag_in[gi] = 1'b0;
            end else begin : g_mid
                assign w_flag_in[gi] = w_flag[gi+1];
            end
            tsts_cell #(
                .IW  (IW),
                .IDX (gi)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_sel     (w_sel),
                .i_flag    (w_flag_in[gi]),
                .o_flag    (w_flag[gi]),
                .o_preempt (w_preempt[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tick      = r_tick;
        n_ts        = r_ts;
        n_tpu       = r_tpu;
        n_run_slot  = r_run_slot;
        n_run_valid = r_run_valid;
        n_nfs       = r_nfs;
        n_prod      = r_prod;
        n_preempt   = r_preempt;
        n_out_valid = 1'b0;
        n_kind      = r_kind;
        n_pid       = r_pid;
        n_none      = 1'b0;
        n_last      = r_last;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLICE: n_ts  = i_cfg_data;
                CFG_TPU:   n_tpu = i_cfg_data;
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_opcode)
                        OP_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_state = S_CMP;
                        end
                        OP_CREATE: begin
                            n_out_valid = 1'b1;
                            n_last      = 1'b1;
                            if (w_full) begin
                                n_kind = KIND_CR_FAIL;
                                n_pid  = '0;
                            end else begin
                                n_kind = KIND_PUSH;
                                n_pid  = PID_W'(r_nfs[IW-1:0]);
                                n_nfs  = r_nfs + 1'b1;
                            end
                        end
                        OP_SLEEP: begin
                            if (r_run_valid) begin
                                n_prod  = {16'd0, r_tpu} * {16'd0, i_sleep_units};
                                n_state = S_SLP;
                            end
                        end
                        OP_DISPATCH: begin
                            if (w_dpid_ok) begin
                                n_run_slot  = IW'(i_dispatch_pid);
                                n_run_valid = 1'b1;
                            end
                        end
                        OP_GETPID: begin
                            n_out_valid = 1'b1;
                            n_kind      = KIND_PID;
                            n_pid       = r_run_valid ? PID_W'(r_run_slot) : '0;
                            n_none      = !r_run_valid;
                            n_last      = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CMP: begin
                n_preempt = |w_preempt;
                n_cnt     = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // cell 0 holds the wake flag of slot r_cnt
                n_out_valid = w_flag[0];
                n_kind      = KIND_PUSH;
                n_pid       = PID_W'(r_cnt);
                n_last      = !(|w_flag[SLOT_COUNT-1:1]) && !r_preempt;
                if (r_cnt == IW'(SLOT_COUNT - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (r_preempt) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_PUSH;
                    n_pid       = PID_W'(r_run_slot);
                    n_last      = 1'b1;
                    n_run_valid = 1'b0;
                end
                n_state = S_IDLE;
            end
            S_SLP: begin
                n_out_valid = 1'b1;
                n_kind      = KIND_RUN_CLR;
                n_pid       = PID_W'(r_run_slot);
                n_last      = 1'b1;
                n_run_valid = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_tick      <= '0;
            r_ts        <= SLICE_RST;
            r_tpu       <= TPU_RST;
            r_run_slot  <= '0;
            r_run_valid <= 1'b0;
            r_nfs       <= (IW+1)'(1);
            r_preempt   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tick      <= n_tick;
            r_ts        <= n_ts;
            r_tpu       <= n_tpu;
            r_run_slot  <= n_run_slot;
            r_run_valid <= n_run_valid;
            r_nfs       <= n_nfs;
            r_preempt   <= n_preempt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_kind <= n_kind;
        r_pid  <= n_pid;
        r_none <= n_none;
        r_last <= n_last;
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_pid          = r_pid;
    assign o_none_running = r_none;
    assign o_last         = r_last;

endmodule

FILE: hw/rtl/tsts_checker.sv
// tsts_checker: port-level assertions on the scheduler results, bound to
// the top level; depends on tsts_pkg
module tsts_checker
    import tsts_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [OPCODE_W-1:0] i_opcode,
    input logic                o_valid,
    input logic [KIND_W-1:0]   o_kind,
    input logic [PID_W-1:0]    o_pid,
    input logic                o_none_running,
    input logic                o_last
);

    // a get-pid item answers in the next cycle with a single result
    a_getpid_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_GETPID)
        |=> o_valid && (o_kind == KIND_PID) && o_last)
        else $error("get-pid item without a single reply");

    // a tick item raises busy while it scans the table
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_TICK) |=> busy)
        else $error("tick item did not hold busy");

    // none_running only on a pid reply, and then with pid zero
    a_none_only_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_none_running |-> (o_kind == KIND_PID) && (o_pid == '0))
        else $error("none_running set outside an empty pid reply");

    // create failure is a lone result with pid zero
    a_create_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_CR_FAIL) |-> o_last && (o_pid == '0))
        else $error("malformed create failure");

endmodule

bind tick_sleep_timeslice_scheduler tsts_checker u_tsts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_opcode       (i_opcode),
    .o_valid        (o_valid),
    .o_kind         (o_kind),
    .o_pid          (o_pid),
    .o_none_running (o_none_running),
    .o_last         (o_last)
);
